// File: hw/rtl/cbq_pkg.sv
// Shared types and constants of the cascaded biquad equalizer.
// Used by cbq_mac, cascaded_biquad_equalizer_unit and cbq_checker.
`timescale 1ns / 1ps
`default_nettype none

package cbq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 2 * COEF_W;
  // five products of 2^30 magnitude at most, plus sign and rounding headroom
  localparam int ACC_W     = 36;
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  localparam logic [CFG_W-1:0] COEF_RESET = 64'h0000_0000_2000_0008;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 36'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -36'sd32768;

  // term steps of one band, then drain of the product register and rounding
  localparam logic [2:0] STEP_B0    = 3'd0;
  localparam logic [2:0] STEP_A1X   = 3'd1;
  localparam logic [2:0] STEP_B2    = 3'd2;
  localparam logic [2:0] STEP_A1Y   = 3'd3;
  localparam logic [2:0] STEP_A2    = 3'd4;
  localparam logic [2:0] STEP_DRAIN = 3'd5;
  localparam logic [2:0] STEP_ROUND = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic issue;  // operands valid this cycle
    logic first;  // product starts a new sum
    logic neg;    // product is subtracted
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/cbq_mac.sv
// Shared multiply-accumulate unit: registered 16x16 signed product, then
// a wide accumulate. Depends on cbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbq_mac (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  cbq_pkg::mac_ctl_t               ctl,
  input  wire  logic signed [cbq_pkg::COEF_W-1:0]   coef,
  input  wire  logic signed [cbq_pkg::SAMPLE_W-1:0] data,
  output logic signed [cbq_pkg::ACC_W-1:0]      acc
);

  logic signed [cbq_pkg::PROD_W-1:0] prod_r;
  logic                              add_r;
  logic                              first_r;
  logic                              neg_r;
  logic signed [cbq_pkg::ACC_W-1:0]  acc_r;
  logic signed [cbq_pkg::ACC_W-1:0]  prod_ext;
  logic signed [cbq_pkg::ACC_W-1:0]  base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r <= 1'b0;
    end else begin
      add_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r  <= coef * data;
      first_r <= ctl.first;
      neg_r   <= ctl.neg;
    end
  end

  assign prod_ext = {{(cbq_pkg::ACC_W - cbq_pkg::PROD_W){prod_r[cbq_pkg::PROD_W-1]}}, prod_r};
  assign base     = first_r ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (add_r) begin
      acc_r <= neg_r ? (base - prod_ext) : (base + prod_ext);
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/cascaded_biquad_equalizer_unit.sv
// Top level of the cascaded biquad equalizer: sequencer, coefficient
// registers, band histories and output register. Depends on cbq_pkg, cbq_mac.
`timescale 1ns / 1ps
`default_nettype none

// Each sample runs through NUM_BANDS biquad bands on one shared multiplier-
// accumulator. A band runs five product steps, a drain step in which the last
// product reaches the sum, and a rounding and saturation step. After an input
// transfer in_tready stays low while the bands run and until the result is
// loaded into the output register, so a new sample is taken only once the
// last one has been through every band; the one shared MAC sets that limit. A
// result still held on the output stretches the item in work until the held
// result leaves. The next sample is taken while a finished result still waits
// on the output. The user must write coefficients through the cfg port only
// while no sample is in work; the block itself does not enforce it. Indexes
// above 7 are ignored. Histories reset to zero with no clearing pass.
module cascaded_biquad_equalizer_unit #(
  parameter int NUM_BANDS      = 8,
  parameter int COEF_FRAC_BITS = 13
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // input stream
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  input  wire  logic signed [cbq_pkg::SAMPLE_W-1:0]  in_tdata,   // [15:0] sample_in
  input  wire  logic [0:0]                           in_tuser,   // [0] clear_history
  // result stream
  output logic                                       out_tvalid,
  input  wire                                        out_tready,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]        out_tdata,  // [15:0] sample_out
  output logic [0:0]                                 out_tuser,  // [0] saturated
  // coefficient writes
  input  wire                                        cfg_valid,
  output logic                                       cfg_ready,
  input  wire  logic [cbq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  logic [cbq_pkg::CFG_W-1:0]            cfg_data
);

  localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);
  localparam logic signed [cbq_pkg::ACC_W-1:0] ROUND_BIAS =
    cbq_pkg::ACC_W'(1) << (COEF_FRAC_BITS - 1);

  cbq_pkg::state_t state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;

  logic [cbq_pkg::CFG_W-1:0] coef_r [cbq_pkg::REG_COUNT];

  logic signed [cbq_pkg::SAMPLE_W-1:0] x1_r [NUM_BANDS];
  logic signed [cbq_pkg::SAMPLE_W-1:0] x2_r [NUM_BANDS];
  logic signed [cbq_pkg::SAMPLE_W-1:0] y1_r [NUM_BANDS];
  logic signed [cbq_pkg::SAMPLE_W-1:0] y2_r [NUM_BANDS];

  logic signed [cbq_pkg::SAMPLE_W-1:0] x_r;
  logic                                clip_r;
  logic                                out_valid_r;
  logic signed [cbq_pkg::SAMPLE_W-1:0] out_data_r;
  logic                                out_sat_r;

  logic in_xfer;
  logic do_round;
  logic load_out;

  cbq_pkg::mac_ctl_t                   mac_ctl;
  logic signed [cbq_pkg::COEF_W-1:0]   mac_coef;
  logic signed [cbq_pkg::SAMPLE_W-1:0] mac_data;
  logic signed [cbq_pkg::ACC_W-1:0]    mac_acc;

  logic [cbq_pkg::CFG_W-1:0]           band_coef;
  logic signed [cbq_pkg::COEF_W-1:0]   c_b0, c_b2, c_a1, c_a2;

  logic signed [cbq_pkg::ACC_W-1:0]    rnd_sum;
  logic signed [cbq_pkg::ACC_W-1:0]    rnd_q;
  logic                                clip_hi, clip_lo;
  logic signed [cbq_pkg::SAMPLE_W-1:0] y_sat;

  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    band_nxt  = band_r;
    case (state_r)
      cbq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = cbq_pkg::ST_RUN;
          step_nxt  = cbq_pkg::STEP_B0;
          band_nxt  = '0;
        end
      end
      cbq_pkg::ST_RUN: begin
        if (step_r == cbq_pkg::STEP_ROUND) begin
          step_nxt = cbq_pkg::STEP_B0;
          band_nxt = band_r + 1'b1;
          if (band_r == LAST_BAND) begin
            state_nxt = cbq_pkg::ST_FINISH;
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      cbq_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = cbq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    do_round      = 1'b0;
    load_out      = 1'b0;
    mac_ctl.issue = 1'b0;
    mac_ctl.first = (step_r == cbq_pkg::STEP_B0);
    mac_ctl.neg   = (step_r == cbq_pkg::STEP_A1X) || (step_r == cbq_pkg::STEP_A2);
    case (state_r)
      cbq_pkg::ST_IDLE:   in_tready = 1'b1;
      cbq_pkg::ST_RUN: begin
        mac_ctl.issue = (step_r <= cbq_pkg::STEP_A2);
        do_round      = (step_r == cbq_pkg::STEP_ROUND);
      end
      cbq_pkg::ST_FINISH: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbq_pkg::ST_IDLE;
      step_r  <= cbq_pkg::STEP_B0;
      band_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      band_r  <= band_nxt;
    end
  end

  // ---------------- coefficient registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbq_pkg::REG_COUNT; i++) begin
        coef_r[i] <= cbq_pkg::COEF_RESET;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < cbq_pkg::CFG_IDX_W'(cbq_pkg::REG_COUNT))) begin
      coef_r[cfg_index[cbq_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign band_coef = coef_r[cbq_pkg::REG_IDX_W'(band_r)];
  assign c_b0 = band_coef[15:0];
  assign c_b2 = band_coef[31:16];
  assign c_a1 = band_coef[47:32];
  assign c_a2 = band_coef[63:48];

  // ---------------- operand select ----------------
  always_comb begin
    case (step_r)
      cbq_pkg::STEP_B0: begin
        mac_coef = c_b0;
        mac_data = x_r;
      end
      cbq_pkg::STEP_A1X: begin
        mac_coef = c_a1;
        mac_data = x1_r[band_r];
      end
      cbq_pkg::STEP_B2: begin
        mac_coef = c_b2;
        mac_data = x2_r[band_r];
      end
      cbq_pkg::STEP_A1Y: begin
        mac_coef = c_a1;
        mac_data = y1_r[band_r];
      end
      cbq_pkg::STEP_A2: begin
        mac_coef = c_a2;
        mac_data = y2_r[band_r];
      end
      default: begin
        mac_coef = '0;
        mac_data = '0;
      end
    endcase
  end

  cbq_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (mac_coef),
    .data  (mac_data),
    .acc   (mac_acc)
  );

  // ---------------- round and saturate ----------------
  assign rnd_sum = mac_acc + ROUND_BIAS;
  assign rnd_q   = rnd_sum >>> COEF_FRAC_BITS;
  assign clip_hi = rnd_q > cbq_pkg::SAT_MAX;
  assign clip_lo = rnd_q < cbq_pkg::SAT_MIN;

  always_comb begin
    if (clip_hi) begin
      y_sat = 16'sh7FFF;
    end else if (clip_lo) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = rnd_q[cbq_pkg::SAMPLE_W-1:0];
    end
  end

  // ---------------- band histories ----------------
  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_tuser[0])) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (do_round) begin
      x2_r[band_r] <= x1_r[band_r];
      x1_r[band_r] <= x_r;
      y2_r[band_r] <= y1_r[band_r];
      y1_r[band_r] <= y_sat;
    end
  end

  // running stage input and clip flag of the sample in work
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r    <= in_tdata;
      clip_r <= 1'b0;
    end else if (do_round) begin
      x_r    <= y_sat;
      clip_r <= clip_r || clip_hi || clip_lo;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= x_r;
      out_sat_r  <= clip_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

endmodule

`default_nettype wire

// File: hw/rtl/cbq_checker.sv
// Port-level checks of the cascaded biquad equalizer, and the bind that
// attaches them to the top level. Depends on cbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbq_checker (
  input wire                                       clk,
  input wire                                       rst_n,
  input wire                                       in_tvalid,
  input wire                                       in_tready,
  input wire                                       out_tvalid,
  input wire                                       out_tready,
  input wire logic [cbq_pkg::SAMPLE_W-1:0]         out_tdata,
  input wire logic [0:0]                           out_tuser,
  input wire                                       cfg_valid,
  input wire                                       cfg_ready
);

  // a transfer on the input makes the block busy in the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready still high after an input transfer");

  // in_tready drops only as the result of an input transfer
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("in_tready fell without an input transfer");

  // the block comes out of reset empty and ready
  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (!out_tvalid && in_tready))
    else $error("block not empty after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  // coefficient writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("cfg write stalled");

endmodule

bind cascaded_biquad_equalizer_unit cbq_checker u_cbq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for cascaded_biquad_equalizer_unit: a bit-exact
// eight-band predictor inside a small scoreboard, random stalls on both streams.
// Depends on cbq_pkg and the equalizer RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_W       = cbq_pkg::SAMPLE_W;
  localparam int COEF_W         = cbq_pkg::COEF_W;
  localparam int CFG_W          = cbq_pkg::CFG_W;
  localparam int CFG_IDX_W      = cbq_pkg::CFG_IDX_W;
  localparam int REG_COUNT      = cbq_pkg::REG_COUNT;
  localparam int NUM_BANDS      = 8;
  localparam int FRAC_BITS      = 13;
  localparam int WATCHDOG_LIMIT = 1000;
  // in_tready stays low after a transfer while every band runs and the result loads
  localparam int BUSY_CYCLES    = 7 * NUM_BANDS + 1;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 228;
  localparam int LAST_CFG_IDX   = (1 << CFG_IDX_W) - 1;
  localparam longint ROUND_BIAS = longint'(1) << (FRAC_BITS - 1);
  localparam longint SAMPLE_HI  = 32767;
  localparam longint SAMPLE_LO  = -32768;
  localparam logic [COEF_W-1:0] UNITY = 16'h2000;

  typedef enum int {
    COEF_WILD,
    COEF_TAME,
    COEF_NEAR_UNITY,
    COEF_MIXED
  } coef_style_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } eq_out_t;

  class cascade_scoreboard;
    logic [CFG_W-1:0]           band_coefs [REG_COUNT];
    logic signed [SAMPLE_W-1:0] x_hist1 [NUM_BANDS];
    logic signed [SAMPLE_W-1:0] x_hist2 [NUM_BANDS];
    logic signed [SAMPLE_W-1:0] y_hist1 [NUM_BANDS];
    logic signed [SAMPLE_W-1:0] y_hist2 [NUM_BANDS];
    eq_out_t                    expected_outputs [$];
    int unsigned                errors;
    int unsigned                results_seen;

    function new();
      int k;
      for (k = 0; k < REG_COUNT; k++) band_coefs[k] = cbq_pkg::COEF_RESET;
      clear_histories();
      errors = 0;
      results_seen = 0;
    endfunction

    function void clear_histories();
      int k;
      for (k = 0; k < NUM_BANDS; k++) begin
        x_hist1[k] = '0;
        x_hist2[k] = '0;
        y_hist1[k] = '0;
        y_hist2[k] = '0;
      end
    endfunction

    function void write_coefs(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      // indexes past the last band are dropped by the block
      if (idx < REG_COUNT) band_coefs[idx] = data;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // runs one accepted sample through the cascade and queues the result
    function void take_sample(logic signed [SAMPLE_W-1:0] sample_in, logic clear);
      logic signed [SAMPLE_W-1:0] x, y;
      logic signed [COEF_W-1:0]   b0, b2, a1, a2;
      longint                     acc, q;
      eq_out_t                    res;
      int                         k;
      if (clear) clear_histories();
      x = sample_in;
      res.clipped = 1'b0;
      for (k = 0; k < NUM_BANDS; k++) begin
        b0 = band_coefs[k][15:0];
        b2 = band_coefs[k][31:16];
        a1 = band_coefs[k][47:32];
        a2 = band_coefs[k][63:48];
        acc = longint'(b0) * longint'(x)
            - longint'(a1) * longint'(x_hist1[k])
            + longint'(b2) * longint'(x_hist2[k])
            + longint'(a1) * longint'(y_hist1[k])
            - longint'(a2) * longint'(y_hist2[k]);
        q = (acc + ROUND_BIAS) >>> FRAC_BITS;
        if (q > SAMPLE_HI) begin
          y = 16'sh7fff;
          res.clipped = 1'b1;
        end else if (q < SAMPLE_LO) begin
          y = 16'sh8000;
          res.clipped = 1'b1;
        end else begin
          y = q[SAMPLE_W-1:0];
        end
        x_hist2[k] = x_hist1[k];
        x_hist1[k] = x;
        y_hist2[k] = y_hist1[k];
        y_hist1[k] = y;
        x = y;
      end
      res.sample = x;
      expected_outputs.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR: result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_output(logic signed [SAMPLE_W-1:0] sample, logic clipped);
      eq_out_t want;
      if (expected_outputs.size() == 0) begin
        report($sformatf("unexpected transfer, sample %0d", sample));
      end else begin
        want = expected_outputs.pop_front();
        if (sample !== want.sample)
          report($sformatf("sample_out %0d, expected %0d", sample, want.sample));
        if (clipped !== want.clipped)
          report($sformatf("saturated %0b, expected %0b", clipped, want.clipped));
      end
      results_seen++;
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic signed [SAMPLE_W-1:0] in_tdata;
  logic [0:0]                 in_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic signed [SAMPLE_W-1:0] out_tdata;
  logic [0:0]                 out_tuser;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  cascade_scoreboard sb;
  int unsigned       rx_wait;
  int unsigned       tx_burst;
  logic              rx_fast;
  int unsigned       idle_cycles;

  cascaded_biquad_equalizer_unit #(
    .NUM_BANDS      (NUM_BANDS),
    .COEF_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // result side: after each transfer hold tready low for a drawn number of cycles
  always @(negedge clk) begin
    if (rx_wait != 0) begin
      out_tready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_output(out_tdata, out_tuser[0]);
      rx_wait = rx_fast ? 0 : $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] pack_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b2,
                                                 logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2);
    return {a2, a1, b2, b0};
  endfunction

  function automatic logic [COEF_W-1:0] around(int centre, int spread);
    return 16'(centre + int'($urandom_range(0, 2 * spread - 1)) - spread);
  endfunction

  function automatic logic [CFG_W-1:0] draw_coefs(coef_style_t style);
    coef_style_t s;
    s = style;
    if (s == COEF_MIXED) s = coef_style_t'($urandom_range(0, 2));
    case (s)
      COEF_TAME:
        return pack_coefs(around(0, 8192), around(0, 4096), around(0, 4096), around(0, 2048));
      COEF_NEAR_UNITY:
        return pack_coefs(around(8192, 512), around(0, 256), around(0, 1024), around(0, 512));
      default:
        return {$urandom, $urandom};
    endcase
  endfunction

  // all tasks start and end just after a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_coefs(idx, data);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_all_bands(logic [CFG_W-1:0] data);
    int k;
    for (k = 0; k < REG_COUNT; k++) write_reg(k[CFG_IDX_W-1:0], data);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] sample, logic clear);
    int unsigned gap;
    if (tx_burst != 0) begin
      gap = 0;
      tx_burst--;
    end else if ($urandom_range(0, 49) == 0) begin
      gap = 0;
      tx_burst = 20;
    end else begin
      gap = $urandom_range(0, 7);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= sample;
    in_tuser[0] <= clear;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(sample, clear);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_random_sample();
    logic signed [SAMPLE_W-1:0] s;
    int unsigned                sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    else if (sel < 3) s = 16'(int'($urandom_range(0, 511)) - 256);
    else s = 16'($urandom);
    send_sample(s, $urandom_range(0, 31) == 0);
  endtask

  initial begin
    int p, n;
    coef_style_t style;
    sb = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    rx_wait     = 0;
    rx_fast     = 1'b0;
    tx_burst    = 0;
    idle_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients: each band is a two-sample delay plus a tiny direct term
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    wait_drained();

    // unity pass-through; writes to unused indexes must leave the bands alone
    write_all_bands(pack_coefs(UNITY, '0, '0, '0));
    write_reg(CFG_IDX_W'(REG_COUNT), '1);
    write_reg(CFG_IDX_W'(LAST_CFG_IDX), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    wait_drained();

    // largest positive coefficients drive the bands into clipping
    write_all_bands({4{16'h7fff}});
    cfg_valid <= 1'b0;
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd100, 1'b0);
    wait_drained();

    // most negative coefficients
    write_all_bands({4{16'h8000}});
    cfg_valid <= 1'b0;
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    wait_drained();

    // rounding at exactly one half: b0 of one LSB on band 0, unity after
    write_all_bands(pack_coefs(UNITY, '0, '0, '0));
    write_reg('0, pack_coefs(16'd1, '0, '0, '0));
    cfg_valid <= 1'b0;
    send_sample(16'sd4096, 1'b1);
    send_sample(-16'sd4096, 1'b1);
    send_sample(16'sd4095, 1'b1);
    send_sample(-16'sd4097, 1'b1);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      style   = coef_style_t'(p % 4);
      rx_fast = (p == 5);
      for (n = 0; n < REG_COUNT; n++) write_reg(n[CFG_IDX_W-1:0], draw_coefs(style));
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, LAST_CFG_IDX)), {$urandom, $urandom});
      cfg_valid <= 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) send_random_sample();
      wait_drained();
    end

    rx_fast = 1'b0;
    repeat (BUSY_CYCLES + 8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/cbq_pkg.sv
hw/rtl/cbq_mac.sv
hw/rtl/cascaded_biquad_equalizer_unit.sv
hw/rtl/cbq_checker.sv
tb/testbench.sv
